@@ rtl/bxd_pkg.sv @@
// Shared types, constants and width helpers for the box average downscaler.
// Used by every module of the block; depends on nothing else.
package bxd_pkg;

   // field and register widths
   localparam int PIX_W       = 8;
   localparam int DIM_W       = 13;
   localparam int BLK_W       = 5;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 13;

   // largest block side the block_size register can carry
   localparam int BLK_CAP     = 31;

   // parameter defaults
   localparam int DEF_MAX_WIDTH = 4096;
   localparam int DEF_MAX_BLOCK = 16;

   // register reset values
   localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH  = 13'd1024;
   localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT = 13'd1024;
   localparam logic [BLK_W-1:0] RST_BLOCK_SIZE   = 5'd3;

   // entries in the queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // register map
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_BLOCK_SIZE   = 2'd2
   } csr_index_type;

   // one classified pixel as it travels from front to back
   typedef struct packed {
      logic             first;
      logic             emit;
      logic             last;
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
   } item_type;

   // effective largest block side
   function automatic int blk_lim(input int max_block);
      return (max_block < BLK_CAP) ? max_block : BLK_CAP;
   endfunction

   // bits of one column sum
   function automatic int sum_w(input int max_block);
      int lim;
      lim = blk_lim(max_block);
      return $clog2(lim * lim * ((1 << PIX_W) - 1) + 1);
   endfunction

   // bits of the block area
   function automatic int area_w(input int max_block);
      int lim;
      lim = blk_lim(max_block);
      return $clog2(lim * lim + 1);
   endfunction

   // fraction bits of the reciprocal, enough for an exact quotient
   function automatic int recip_shift(input int max_block);
      return sum_w(max_block) + area_w(max_block);
   endfunction

endpackage

@@ rtl/bxd_front.sv @@
// Front end: tracks the raster position of each accepted pixel and classifies it.
// Pixels inside a whole block are pushed to the queue; depends on bxd_pkg.
module bxd_front #(
   parameter int MAX_WIDTH = bxd_pkg::DEF_MAX_WIDTH,
   localparam int COL_W = $clog2(MAX_WIDTH)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      restart,
   input  logic                      take,
   input  logic [bxd_pkg::DIM_W-1:0] img_w,
   input  logic [bxd_pkg::DIM_W-1:0] img_h,
   input  logic [bxd_pkg::BLK_W-1:0] blk,
   input  logic [bxd_pkg::PIX_W-1:0] red,
   input  logic [bxd_pkg::PIX_W-1:0] green,
   input  logic [bxd_pkg::PIX_W-1:0] blue,
   output logic                      push,
   output logic [COL_W-1:0]          push_idx,
   output bxd_pkg::item_type         push_item
);
   import bxd_pkg::*;

   localparam int OCNT_W = $clog2(MAX_WIDTH + 1);
   localparam int BASE_W = DIM_W + 2;

   logic [DIM_W-1:0]  col_pos_ff, col_pos_in;
   logic [DIM_W-1:0]  row_pos_ff, row_pos_in;
   logic [BLK_W-1:0]  cib_ff, cib_in;
   logic [BLK_W-1:0]  rib_ff, rib_in;
   logic [OCNT_W-1:0] ocol_ff, ocol_in;
   logic [DIM_W-1:0]  col_base_ff, col_base_in;
   logic [DIM_W-1:0]  row_base_ff, row_base_in;

   logic [BASE_W-1:0] blk_x, blk2_x, w_x, h_x, col_base_x, row_base_x;
   logic [BLK_W-1:0]  blk_end;
   logic              col_fit, row_fit, col_edge, row_edge;
   logic              cib_wrap, rib_wrap, row_end, frame_end;

   // block fit and edge tests against the frame size
   always_comb begin
      blk_x      = BASE_W'(blk);
      blk2_x     = BASE_W'(blk) << 1;
      w_x        = BASE_W'(img_w);
      h_x        = BASE_W'(img_h);
      col_base_x = BASE_W'(col_base_ff);
      row_base_x = BASE_W'(row_base_ff);
      col_fit    = (col_base_x + blk_x) <= w_x;
      row_fit    = (row_base_x + blk_x) <= h_x;
      col_edge   = (col_base_x + blk2_x) > w_x;
      row_edge   = (row_base_x + blk2_x) > h_x;
      blk_end    = blk - BLK_W'(1);
      cib_wrap   = cib_ff == blk_end;
      rib_wrap   = rib_ff == blk_end;
      row_end    = col_pos_ff == (img_w - DIM_W'(1));
      frame_end  = row_pos_ff == (img_h - DIM_W'(1));
   end

   // classification of the current pixel
   always_comb begin
      push            = take && col_fit && row_fit;
      push_idx        = ocol_ff[COL_W-1:0];
      push_item.first = (cib_ff == '0) && (rib_ff == '0);
      push_item.emit  = cib_wrap && rib_wrap;
      push_item.last  = cib_wrap && rib_wrap && col_edge && row_edge;
      push_item.red   = red;
      push_item.green = green;
      push_item.blue  = blue;
   end

   // position counters for the next pixel
   always_comb begin
      col_pos_in  = col_pos_ff + DIM_W'(1);
      cib_in      = cib_ff + BLK_W'(1);
      ocol_in     = ocol_ff;
      col_base_in = col_base_ff;
      row_pos_in  = row_pos_ff;
      rib_in      = rib_ff;
      row_base_in = row_base_ff;
      if (cib_wrap) begin
         cib_in      = '0;
         ocol_in     = ocol_ff + OCNT_W'(1);
         col_base_in = col_base_ff + DIM_W'(blk);
      end
      if (row_end) begin
         col_pos_in  = '0;
         cib_in      = '0;
         ocol_in     = '0;
         col_base_in = '0;
         row_pos_in  = row_pos_ff + DIM_W'(1);
         if (rib_wrap) begin
            rib_in      = '0;
            row_base_in = row_base_ff + DIM_W'(blk);
         end else begin
            rib_in = rib_ff + BLK_W'(1);
         end
         if (frame_end) begin
            row_pos_in  = '0;
            rib_in      = '0;
            row_base_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         col_pos_ff  <= '0;
         row_pos_ff  <= '0;
         cib_ff      <= '0;
         rib_ff      <= '0;
         ocol_ff     <= '0;
         col_base_ff <= '0;
         row_base_ff <= '0;
      end else if (take) begin
         col_pos_ff  <= col_pos_in;
         row_pos_ff  <= row_pos_in;
         cib_ff      <= cib_in;
         rib_ff      <= rib_in;
         ocol_ff     <= ocol_in;
         col_base_ff <= col_base_in;
         row_base_ff <= row_base_in;
      end
   end

endmodule

@@ rtl/bxd_queue.sv @@
// Short first-in first-out queue between the front end and the back end.
// Depth comes from bxd_pkg; the head word is shown whenever the queue is not empty.
module bxd_queue #(
   parameter int DATA_W = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   input  logic              pop,
   output logic [DATA_W-1:0] pop_data,
   output logic              empty
);
   import bxd_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [DATA_W-1:0] slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   // occupancy and pointer updates
   always_comb begin
      full      = count_ff == CNT_W'(QUEUE_DEPTH);
      empty     = count_ff == '0;
      do_push   = push && !full;
      do_pop    = pop && !empty;
      wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
      pop_data  = slot_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_in;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_in;
         end
         count_ff <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/bxd_recip.sv @@
// Reciprocal unit: computes ceil(2^K / (b*b)) bit-serially after reset and
// after every block size write, so the back end divides by a multiply; uses bxd_pkg.
module bxd_recip #(
   parameter int MAX_BLOCK = bxd_pkg::DEF_MAX_BLOCK,
   localparam int RECIP_W = bxd_pkg::recip_shift(MAX_BLOCK) + 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [bxd_pkg::BLK_W-1:0] blk,
   output logic                      busy,
   output logic [RECIP_W-1:0]        recip
);
   import bxd_pkg::*;

   localparam int SHIFT  = recip_shift(MAX_BLOCK);
   localparam int AREA_W = area_w(MAX_BLOCK);
   localparam int CNT_W  = $clog2(SHIFT);

   typedef enum logic [1:0] {
      RCP_IDLE,
      RCP_LOAD,
      RCP_RUN
   } rcp_state_type;

   rcp_state_type      state_ff;
   logic [AREA_W-1:0]  area_ff;
   logic [AREA_W-1:0]  rem_ff, rem_in;
   logic [SHIFT-1:0]   quo_ff, quo_in;
   logic [CNT_W-1:0]   cnt_ff;
   logic [RECIP_W-1:0] recip_ff;
   logic [2*BLK_W-1:0] square;
   logic [AREA_W:0]    trial;

   // one restoring step; the dividend is all ones
   always_comb begin
      square = {{BLK_W{1'b0}}, blk} * {{BLK_W{1'b0}}, blk};
      trial  = {rem_ff, 1'b1};
      if (trial >= {1'b0, area_ff}) begin
         rem_in = AREA_W'(trial - {1'b0, area_ff});
         quo_in = {quo_ff[SHIFT-2:0], 1'b1};
      end else begin
         rem_in = trial[AREA_W-1:0];
         quo_in = {quo_ff[SHIFT-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= RCP_LOAD;
      end else if (start) begin
         state_ff <= RCP_LOAD;
      end else begin
         case (state_ff)
            RCP_LOAD: begin
               area_ff  <= square[AREA_W-1:0];
               rem_ff   <= '0;
               quo_ff   <= '0;
               cnt_ff   <= '0;
               state_ff <= RCP_RUN;
            end
            RCP_RUN: begin
               rem_ff <= rem_in;
               quo_ff <= quo_in;
               cnt_ff <= cnt_ff + CNT_W'(1);
               if (cnt_ff == CNT_W'(SHIFT - 1)) begin
                  recip_ff <= RECIP_W'(quo_in) + RECIP_W'(1);
                  state_ff <= RCP_IDLE;
               end
            end
            default: begin
               state_ff <= RCP_IDLE;
            end
         endcase
      end
   end

   assign busy  = state_ff != RCP_IDLE;
   assign recip = recip_ff;

endmodule

@@ rtl/bxd_back.sv @@
// Back end: read-modify-write of the per-column sums, reciprocal multiply and
// the result register. Depends on bxd_pkg.
module bxd_back #(
   parameter int MAX_WIDTH = bxd_pkg::DEF_MAX_WIDTH,
   parameter int MAX_BLOCK = bxd_pkg::DEF_MAX_BLOCK,
   localparam int COL_W = $clog2(MAX_WIDTH),
   localparam int Q_W = COL_W + $bits(bxd_pkg::item_type),
   localparam int RECIP_W = bxd_pkg::recip_shift(MAX_BLOCK) + 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      q_empty,
   input  logic [Q_W-1:0]            q_data,
   output logic                      q_pop,
   input  logic [RECIP_W-1:0]        recip,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [bxd_pkg::PIX_W-1:0] rsp_red_out,
   output logic [bxd_pkg::PIX_W-1:0] rsp_green_out,
   output logic [bxd_pkg::PIX_W-1:0] rsp_blue_out,
   output logic                      rsp_frame_last
);
   import bxd_pkg::*;

   localparam int ITEM_W = $bits(item_type);
   localparam int SUM_W  = sum_w(MAX_BLOCK);
   localparam int SHIFT  = recip_shift(MAX_BLOCK);
   localparam int PROD_W = SUM_W + RECIP_W;

   // lanes: 0 red, 1 green, 2 blue
   logic [2:0][SUM_W-1:0] sum_mem [MAX_WIDTH];

   logic                  adv;
   logic [COL_W-1:0]      head_idx;
   item_type              head_item;

   logic                  s1_valid_ff;
   logic [COL_W-1:0]      s1_idx_ff;
   item_type              s1_item_ff;
   logic [2:0][SUM_W-1:0] rd_ff;
   logic [2:0][PIX_W-1:0] s1_pix;
   logic [2:0][SUM_W-1:0] old_sum, new_sum;
   logic                  wr_en;

   logic                  fw_ok_ff;
   logic [COL_W-1:0]      fw_idx_ff;
   logic [2:0][SUM_W-1:0] fw_data_ff;

   logic                  s2_valid_ff;
   logic                  s2_last_ff;
   logic [2:0][SUM_W-1:0] s2_sum_ff;
   logic [2:0][PROD_W-1:0] prod;

   logic                  out_valid_ff;
   logic                  out_last_ff;
   logic [2:0][PIX_W-1:0] out_pix_ff;

   // pipeline advances whenever the result register is free
   always_comb begin
      adv       = !out_valid_ff || rsp_ready;
      q_pop     = adv && !q_empty;
      head_idx  = q_data[Q_W-1 -: COL_W];
      head_item = item_type'(q_data[ITEM_W-1:0]);
   end

   // accumulate, with the last write forwarded over the stale read
   always_comb begin
      s1_pix[0] = s1_item_ff.red;
      s1_pix[1] = s1_item_ff.green;
      s1_pix[2] = s1_item_ff.blue;
      old_sum   = (fw_ok_ff && (fw_idx_ff == s1_idx_ff)) ? fw_data_ff : rd_ff;
      for (int c = 0; c < 3; c++) begin
         new_sum[c] = s1_item_ff.first ? SUM_W'(s1_pix[c])
                                       : old_sum[c] + SUM_W'(s1_pix[c]);
      end
      wr_en = adv && s1_valid_ff;
   end

   // sum times reciprocal gives the truncated average
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         prod[c] = {{RECIP_W{1'b0}}, s2_sum_ff[c]} * {{SUM_W{1'b0}}, recip};
      end
   end

   // column sum memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         sum_mem[s1_idx_ff] <= new_sum;
      end
      if (q_pop) begin
         rd_ff <= sum_mem[head_idx];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         fw_ok_ff     <= 1'b0;
      end else begin
         if (adv) begin
            s1_valid_ff  <= !q_empty;
            s2_valid_ff  <= s1_valid_ff && s1_item_ff.emit;
            out_valid_ff <= s2_valid_ff;
         end
         if (wr_en) begin
            fw_ok_ff <= 1'b1;
         end
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      if (q_pop) begin
         s1_idx_ff  <= head_idx;
         s1_item_ff <= head_item;
      end
      if (wr_en) begin
         fw_idx_ff  <= s1_idx_ff;
         fw_data_ff <= new_sum;
      end
      if (adv) begin
         s2_sum_ff  <= new_sum;
         s2_last_ff <= s1_item_ff.last;
      end
      if (adv && s2_valid_ff) begin
         for (int c = 0; c < 3; c++) begin
            out_pix_ff[c] <= prod[c][SHIFT +: PIX_W];
         end
         out_last_ff <= s2_last_ff;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_red_out    = out_pix_ff[0];
   assign rsp_green_out  = out_pix_ff[1];
   assign rsp_blue_out   = out_pix_ff[2];
   assign rsp_frame_last = out_last_ff;

endmodule

@@ rtl/box_average_downscale.sv @@
// Box average downscaler: top level with the configuration registers.
// Depends on bxd_pkg, bxd_front, bxd_queue, bxd_recip and bxd_back.
//
// Usage:
//   req_* takes one RGB pixel per word in raster order. rsp_* gives one averaged
//   pixel per whole block_size x block_size block, in block raster order, with
//   rsp_frame_last set on the last block of the frame. csr_* writes
//   image_width (0), image_height (1) and block_size (2); any write to these
//   restarts the frame at its first pixel, and column sums are kept.
// Timing:
//   one pixel per clock while req_ready is high, set by one read-modify-write of
//   the column sum memory per pixel with the previous write forwarded. A pixel
//   that closes a block passes the queue, the s1 and s2 stages and the result
//   register before its result shows. After reset and after each block_size
//   write the reciprocal unit loads the block area and runs its restoring steps
//   while req_ready is low. The sum memory needs no clearing pass.
// Stall:
//   when rsp_ready is low the back end holds, the 4-word queue fills and then
//   req_ready drops. Reset is synchronous and active high.
module box_average_downscale #(
   parameter int MAX_WIDTH = bxd_pkg::DEF_MAX_WIDTH,
   parameter int MAX_BLOCK = bxd_pkg::DEF_MAX_BLOCK
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [bxd_pkg::PIX_W-1:0]      req_red_in,
   input  logic [bxd_pkg::PIX_W-1:0]      req_green_in,
   input  logic [bxd_pkg::PIX_W-1:0]      req_blue_in,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [bxd_pkg::PIX_W-1:0]      rsp_red_out,
   output logic [bxd_pkg::PIX_W-1:0]      rsp_green_out,
   output logic [bxd_pkg::PIX_W-1:0]      rsp_blue_out,
   output logic                           rsp_frame_last,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [bxd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bxd_pkg::CSR_DATA_W-1:0] csr_data
);
   import bxd_pkg::*;

   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int ITEM_W  = $bits(item_type);
   localparam int Q_W     = COL_W + ITEM_W;
   localparam int BLK_LIM = blk_lim(MAX_BLOCK);
   localparam int RECIP_W = recip_shift(MAX_BLOCK) + 1;

   logic [DIM_W-1:0]   width_ff, height_ff;
   logic [BLK_W-1:0]   block_ff;
   logic [DIM_W-1:0]   w_eff, h_eff;
   logic [BLK_W-1:0]   b_eff;
   logic               csr_take, csr_known, restart, rcp_start;
   logic               take;

   logic               f_push;
   logic [COL_W-1:0]   f_idx;
   item_type           f_item;
   logic               q_full, q_empty, q_pop;
   logic [Q_W-1:0]     q_head;
   logic               rcp_busy;
   logic [RECIP_W-1:0] recip;

   // register writes
   always_comb begin
      csr_ready = 1'b1;
      csr_take  = csr_valid && csr_ready;
      case (csr_index)
         CSR_IMAGE_WIDTH, CSR_IMAGE_HEIGHT, CSR_BLOCK_SIZE: csr_known = 1'b1;
         default: csr_known = 1'b0;
      endcase
      restart   = csr_take && csr_known;
      rcp_start = csr_take && (csr_index == CSR_BLOCK_SIZE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RST_IMAGE_WIDTH;
         height_ff <= RST_IMAGE_HEIGHT;
         block_ff  <= RST_BLOCK_SIZE;
      end else if (csr_take) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_data[DIM_W-1:0];
            CSR_IMAGE_HEIGHT: height_ff <= csr_data[DIM_W-1:0];
            CSR_BLOCK_SIZE:   block_ff  <= csr_data[BLK_W-1:0];
            default: ;
         endcase
      end
   end

   // zero reads as one, oversize width and block size saturate
   always_comb begin
      if (width_ff == '0) begin
         w_eff = DIM_W'(1);
      end else if (int'(width_ff) > MAX_WIDTH) begin
         w_eff = DIM_W'(MAX_WIDTH);
      end else begin
         w_eff = width_ff;
      end
      h_eff = (height_ff == '0) ? DIM_W'(1) : height_ff;
      if (block_ff == '0) begin
         b_eff = BLK_W'(1);
      end else if (int'(block_ff) > BLK_LIM) begin
         b_eff = BLK_W'(BLK_LIM);
      end else begin
         b_eff = block_ff;
      end
   end

   // input handshake
   assign req_ready = !q_full && !rcp_busy;
   assign take      = req_valid && req_ready;

   bxd_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .restart   (restart),
      .take      (take),
      .img_w     (w_eff),
      .img_h     (h_eff),
      .blk       (b_eff),
      .red       (req_red_in),
      .green     (req_green_in),
      .blue      (req_blue_in),
      .push      (f_push),
      .push_idx  (f_idx),
      .push_item (f_item)
   );

   bxd_queue #(
      .DATA_W (Q_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_push),
      .push_data ({f_idx, f_item}),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_head),
      .empty     (q_empty)
   );

   bxd_recip #(
      .MAX_BLOCK (MAX_BLOCK)
   ) u_recip (
      .clock (clock),
      .reset (reset),
      .start (rcp_start),
      .blk   (b_eff),
      .busy  (rcp_busy),
      .recip (recip)
   );

   bxd_back #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_BLOCK (MAX_BLOCK)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_empty),
      .q_data         (q_head),
      .q_pop          (q_pop),
      .recip          (recip),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_red_out    (rsp_red_out),
      .rsp_green_out  (rsp_green_out),
      .rsp_blue_out   (rsp_blue_out),
      .rsp_frame_last (rsp_frame_last)
   );

endmodule

@@ rtl/bxd_checker.sv @@
// Port-level checks for the box average downscaler, bound to the top level.
// Depends on bxd_pkg and box_average_downscale.
module bxd_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [bxd_pkg::PIX_W-1:0]      rsp_red_out,
   input logic [bxd_pkg::PIX_W-1:0]      rsp_green_out,
   input logic [bxd_pkg::PIX_W-1:0]      rsp_blue_out,
   input logic                           rsp_frame_last,
   input logic                           csr_valid,
   input logic                           csr_ready,
   input logic [bxd_pkg::CSR_IDX_W-1:0]  csr_index
);
   import bxd_pkg::*;

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_red_out)
         && $stable(rsp_green_out) && $stable(rsp_blue_out) && $stable(rsp_frame_last))
      else $error("result word changed while stalled");

   // reciprocal computation blocks input right after reset
   a_reset_busy: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("input accepted before reciprocal is ready");

   // no result is pending right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown right after reset");

   // a block size write restarts the reciprocal and blocks input
   a_blk_recalc: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready && (csr_index == CSR_BLOCK_SIZE) |=> !req_ready)
      else $error("input accepted during reciprocal update");

endmodule

bind box_average_downscale bxd_checker u_bxd_checker (.*);
